FILE: design/assert_macros.svh
// Assertion macros for the checker file mck_checker.sv.
// Uses clk and rst_n from the scope of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mck_pkg.sv
// Package for the morse character keyer: widths, codes, letter table and
// the command/status structs between controller and datapath. No dependencies.
package mck_pkg;

    localparam int CHAR_W    = 8;
    localparam int UNIT_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 4;
    localparam int CNT_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_DOT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYM_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_GAP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE     = 3'd4;

    localparam logic [UNIT_W-1:0] DOT_RESET      = 4'd1;
    localparam logic [UNIT_W-1:0] DASH_RESET     = 4'd3;
    localparam logic [UNIT_W-1:0] SYM_GAP_RESET  = 4'd1;
    localparam logic [UNIT_W-1:0] CHAR_GAP_RESET = 4'd3;
    localparam logic [UNIT_W-1:0] SPACE_RESET    = 4'd3;

    localparam logic [CHAR_W-1:0] ASCII_A     = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    typedef enum logic [1:0] {
        SEG_MARK,
        SEG_SYM_GAP,
        SEG_SPACE,
        SEG_CLOSE
    } seg_kind_t;

    typedef struct packed {
        logic      load;
        logic      emit;
        seg_kind_t kind;
        logic      advance;
    } mck_cmd_t;

    typedef struct packed {
        logic out_free;
        logic sym_pending;
        logic space_pending;
    } mck_status_t;

    // High nibble: symbol count. Low nibble: symbols, first in bit 0, 1 = dash.
    function automatic logic [7:0] letter_code(input logic [4:0] idx);
        logic [7:0] code;
        case (idx)
            5'd0:    code = 8'h22;
            5'd1:    code = 8'h41;
            5'd2:    code = 8'h45;
            5'd3:    code = 8'h31;
            5'd4:    code = 8'h10;
            5'd5:    code = 8'h44;
            5'd6:    code = 8'h33;
            5'd7:    code = 8'h40;
            5'd8:    code = 8'h20;
            5'd9:    code = 8'h4E;
            5'd10:   code = 8'h35;
            5'd11:   code = 8'h42;
            5'd12:   code = 8'h23;
            5'd13:   code = 8'h21;
            5'd14:   code = 8'h37;
            5'd15:   code = 8'h46;
            5'd16:   code = 8'h4B;
            5'd17:   code = 8'h32;
            5'd18:   code = 8'h30;
            5'd19:   code = 8'h11;
            5'd20:   code = 8'h34;
            5'd21:   code = 8'h48;
            5'd22:   code = 8'h36;
            5'd23:   code = 8'h49;
            5'd24:   code = 8'h4D;
            5'd25:   code = 8'h43;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

FILE: design/mck_char_if.sv
// Character input channel: valid/ready handshake with an 8-bit ASCII code.
// Depends on mck_pkg.
interface mck_char_if import mck_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

FILE: design/mck_seg_if.sv
// Keying segment output channel: valid/ready handshake with lamp level,
// duration and last-segment flag. Depends on mck_pkg.
interface mck_seg_if import mck_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              lamp_on;
    logic [UNIT_W-1:0] duration_units;
    logic              last_segment;

    modport source (output valid, output lamp_on, output duration_units,
                    output last_segment, input ready);
    modport sink   (input valid, input lamp_on, input duration_units,
                    input last_segment, output ready);
endinterface

FILE: design/mck_ctrl.sv
// Keyer controller: sequences marks, gaps, space and closing gap.
// Depends on mck_pkg; drives the datapath through mck_cmd_t.
module mck_ctrl import mck_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mck_status_t status,
    output mck_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM,
        ST_GAP,
        ST_CLOSE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.emit    = 1'b0;
        cmd.kind    = SEG_CLOSE;
        cmd.advance = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SYM;
                end
            end
            ST_SYM:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.sym_pending)
                    begin
                        cmd.kind   = SEG_MARK;
                        state_next = ST_GAP;
                    end
                    else if (status.space_pending)
                    begin
                        cmd.kind   = SEG_SPACE;
                        state_next = ST_CLOSE;
                    end
                    else
                    begin
                        cmd.kind   = SEG_CLOSE;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_GAP:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = SEG_SYM_GAP;
                    cmd.advance = 1'b1;
                    state_next  = ST_SYM;
                end
            end
            ST_CLOSE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = SEG_CLOSE;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/mck_datapath.sv
// Keyer datapath: timing registers, letter pattern, symbol count and the
// output segment register. Depends on mck_pkg; commanded by mck_ctrl.
module mck_datapath import mck_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CHAR_W-1:0]    char_code,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  mck_cmd_t             cmd,
    output mck_status_t          status,
    mck_seg_if.source            seg_out
);

    logic [UNIT_W-1:0] dot_reg, dash_reg, sym_gap_reg, char_gap_reg, space_units_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]        pat_reg, pat_next;
    logic              space_reg, space_next;
    logic              out_valid_reg, out_valid_next;
    logic              lamp_reg, lamp_next;
    logic [UNIT_W-1:0] dur_reg, dur_next;
    logic              last_reg, last_next;

    logic              is_letter;
    logic [4:0]        letter_idx;
    logic [7:0]        code;
    logic [CHAR_W-1:0] char_off;

    assign is_letter  = (char_code >= ASCII_A) && (char_code <= ASCII_Z);
    assign char_off   = char_code - ASCII_A;
    assign letter_idx = char_off[4:0];
    assign code       = letter_code(letter_idx);

    assign status.out_free      = !out_valid_reg || seg_out.ready;
    assign status.sym_pending   = (cnt_reg != '0);
    assign status.space_pending = space_reg;

    assign seg_out.valid          = out_valid_reg;
    assign seg_out.lamp_on        = lamp_reg;
    assign seg_out.duration_units = dur_reg;
    assign seg_out.last_segment   = last_reg;

    always_comb
    begin
        cnt_next       = cnt_reg;
        pat_next       = pat_reg;
        space_next     = space_reg;
        out_valid_next = out_valid_reg;
        lamp_next      = lamp_reg;
        dur_next       = dur_reg;
        last_next      = last_reg;

        if (cmd.load)
        begin
            cnt_next   = is_letter ? code[6:4] : '0;
            pat_next   = code[3:0];
            space_next = (char_code == ASCII_SPACE);
        end
        if (cmd.advance)
        begin
            cnt_next = cnt_reg - 1'b1;
            pat_next = {1'b0, pat_reg[3:1]};
        end
        if (seg_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            case (cmd.kind)
                SEG_MARK:
                begin
                    lamp_next = 1'b1;
                    dur_next  = pat_reg[0] ? dash_reg : dot_reg;
                    last_next = 1'b0;
                end
                SEG_SYM_GAP:
                begin
                    lamp_next = 1'b0;
                    dur_next  = sym_gap_reg;
                    last_next = 1'b0;
                end
                SEG_SPACE:
                begin
                    lamp_next  = 1'b0;
                    dur_next   = space_units_reg;
                    last_next  = 1'b0;
                    space_next = 1'b0;
                end
                default:
                begin
                    lamp_next = 1'b0;
                    dur_next  = char_gap_reg;
                    last_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg         <= DOT_RESET;
            dash_reg        <= DASH_RESET;
            sym_gap_reg     <= SYM_GAP_RESET;
            char_gap_reg    <= CHAR_GAP_RESET;
            space_units_reg <= SPACE_RESET;
            cnt_reg         <= '0;
            space_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            lamp_reg        <= 1'b0;
            dur_reg         <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            space_reg     <= space_next;
            out_valid_reg <= out_valid_next;
            lamp_reg      <= lamp_next;
            dur_reg       <= dur_next;
            last_reg      <= last_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DOT:      dot_reg         <= cfg_data;
                    CFG_DASH:     dash_reg        <= cfg_data;
                    CFG_SYM_GAP:  sym_gap_reg     <= cfg_data;
                    CFG_CHAR_GAP: char_gap_reg    <= cfg_data;
                    CFG_SPACE:    space_units_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

endmodule

FILE: design/morse_character_keyer.sv
// Morse character keyer top level: controller plus datapath.
// Depends on mck_pkg, mck_char_if, mck_seg_if, mck_ctrl, mck_datapath.
//
// Usage:
//   char_in  - one ASCII code per transfer. Capitals A-Z are keyed as
//              mark/symbol-gap pairs, space as one dark space segment.
//   seg_out  - one keying segment per transfer: lamp level, duration in
//              time units, and last_segment on the closing character gap.
//   cfg_*    - register write port: 0 dot, 1 dash, 2 symbol gap,
//              3 character gap, 4 space. Write only while idle.
// Throughput: one segment per cycle when seg_out is ready; a character
//   of n segments (1 to 9) occupies the controller for its n segments
//   plus the character load. The next character is taken once the
//   closing gap sits in the output register.
// Order: the first segment is registered after the pattern load.
// Reset: registers return to 1/3/1/3/3, no segment pending, ready high.
// Stall: a held seg_out stalls the sequencer; the segment register holds.
module morse_character_keyer import mck_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    mck_char_if.sink             char_in,
    mck_seg_if.source            seg_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    mck_cmd_t    cmd;
    mck_status_t status;

    mck_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mck_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (char_in.char_code),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .seg_out   (seg_out)
    );

endmodule

FILE: design/mck_checker.sv
// Port-level checker for morse_character_keyer, bound to the top level.
// Depends on assert_macros.svh and mck_pkg.
`include "assert_macros.svh"

module mck_checker import mck_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              lamp_on,
    input logic [UNIT_W-1:0] duration_units,
    input logic              last_segment
);

    logic              seg_hold;
    logic              mark_xfer;
    logic [UNIT_W+1:0] seg_word;

    assign seg_hold  = out_valid && !out_ready;
    assign mark_xfer = out_valid && out_ready && lamp_on;
    assign seg_word  = {lamp_on, duration_units, last_segment};

    `CHK_NEXT(a_out_hold, seg_hold, out_valid && $stable(seg_word), "stalled segment changed")
    `CHK_IMPLY(a_lit_not_last, out_valid && lamp_on, !last_segment, "lit segment flagged last")
    `CHK_NEXT(a_one_char, in_valid && in_ready, !in_ready, "second character taken while busy")
    `CHK_NEXT(a_mark_gap, mark_xfer, out_valid && !lamp_on, "mark not followed by gap")

endmodule

bind morse_character_keyer mck_checker u_mck_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (char_in.valid),
    .in_ready       (char_in.ready),
    .out_valid      (seg_out.valid),
    .out_ready      (seg_out.ready),
    .lamp_on        (seg_out.lamp_on),
    .duration_units (seg_out.duration_units),
    .last_segment   (seg_out.last_segment)
);

FILE: verif/morse_character_keyer_tb.sv
// Testbench for morse_character_keyer: drives characters and register writes,
// predicts every keying segment and checks each seg_out transfer in order.
// Depends on mck_pkg, mck_char_if, mck_seg_if and the RTL top level.
module morse_character_keyer_tb import mck_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic              lamp;
        logic [UNIT_W-1:0] dur;
        logic              last;
    } segment_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    mck_char_if char_if ();
    mck_seg_if  seg_if ();

    morse_character_keyer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_if),
        .seg_out   (seg_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the timing registers
    logic [UNIT_W-1:0] dot_len;
    logic [UNIT_W-1:0] dash_len;
    logic [UNIT_W-1:0] sym_gap_len;
    logic [UNIT_W-1:0] char_gap_len;
    logic [UNIT_W-1:0] space_len;

    segment_t pending_segments[$];
    int       bad_count;
    int       shown_count;
    int       cycle_count = 0;
    int       src_stall_pct;
    int       sink_stall_pct;
    int       sink_hold = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic string morse_symbols(input int idx);
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            default: return "--..";
        endcase
    endfunction

    function automatic void key_character(input logic [CHAR_W-1:0] c);
        string    pat;
        segment_t s;
        if (c >= ASCII_A && c <= ASCII_Z)
        begin
            pat = morse_symbols(int'(c - ASCII_A));
            for (int i = 0; i < pat.len(); i++)
            begin
                s.lamp = 1'b1;
                s.dur  = (pat[i] == "-") ? dash_len : dot_len;
                s.last = 1'b0;
                pending_segments.push_back(s);
                s.lamp = 1'b0;
                s.dur  = sym_gap_len;
                pending_segments.push_back(s);
            end
        end
        else if (c == ASCII_SPACE)
        begin
            s.lamp = 1'b0;
            s.dur  = space_len;
            s.last = 1'b0;
            pending_segments.push_back(s);
        end
        s.lamp = 1'b0;
        s.dur  = char_gap_len;
        s.last = 1'b1;
        pending_segments.push_back(s);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    function automatic void note_failure(input string msg);
        bad_count++;
        if (shown_count < MAX_SHOWN)
        begin
            shown_count++;
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sink side: random stalls on seg_out
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            seg_if.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            seg_if.ready <= 1'b1;
            if (sink_stall_pct > 0 && $urandom_range(99) < sink_stall_pct)
                sink_hold <= pick_gap();
        end
    end

    // Segment checker
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && seg_if.valid && seg_if.ready)
        begin
            if (pending_segments.size() == 0)
                note_failure($sformatf("unexpected segment lamp=%0b dur=%0d last=%0b",
                                       seg_if.lamp_on, seg_if.duration_units,
                                       seg_if.last_segment));
            else
            begin
                want = pending_segments.pop_front();
                if (seg_if.lamp_on !== want.lamp || seg_if.duration_units !== want.dur
                    || seg_if.last_segment !== want.last)
                    note_failure($sformatf(
                        "segment mismatch: exp lamp=%0b dur=%0d last=%0b, got %0b/%0d/%0b",
                        want.lamp, want.dur, want.last, seg_if.lamp_on,
                        seg_if.duration_units, seg_if.last_segment));
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = ($urandom_range(99) < src_stall_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            char_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        @(posedge clk);
        while (!char_if.ready)
            @(posedge clk);
        key_character(c);
        @(negedge clk);
    endtask

    task automatic settle(input int limit);
        int n;
        n = 0;
        char_if.valid <= 1'b0;
        while (pending_segments.size() != 0 && n < limit)
        begin
            @(negedge clk);
            n++;
        end
        if (pending_segments.size() != 0)
        begin
            note_failure($sformatf("%0d expected segments never arrived",
                                   pending_segments.size()));
            pending_segments.delete();
        end
        repeat (4) @(negedge clk);
    endtask

    // Block must be idle. Also pokes the unused indexes, which must be ignored.
    task automatic load_config(input logic [UNIT_W-1:0] dot, input logic [UNIT_W-1:0] dash,
                               input logic [UNIT_W-1:0] sgap, input logic [UNIT_W-1:0] cgap,
                               input logic [UNIT_W-1:0] spc);
        logic [CFG_W-1:0] vals [5];
        logic [CFG_IDX_W-1:0] idx [5];
        vals = '{dot, dash, sgap, cgap, spc};
        idx  = '{CFG_DOT, CFG_DASH, CFG_SYM_GAP, CFG_CHAR_GAP, CFG_SPACE};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        for (int k = int'(CFG_SPACE) + 1; k < 2 ** CFG_IDX_W; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data  <= CFG_W'($urandom);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        dot_len      = dot;
        dash_len     = dash;
        sym_gap_len  = sgap;
        char_gap_len = cgap;
        space_len    = spc;
        @(negedge clk);
    endtask

    task automatic test_default_keying();
        logic [CHAR_W-1:0] chars [15];
        chars = '{ASCII_A, ASCII_Z, 8'h45, 8'h54, 8'h51, 8'h4F, ASCII_SPACE, 8'h00,
                  8'hFF, 8'h40, 8'h5B, 8'h61, 8'h30, 8'h7F, 8'h80};
        src_stall_pct  = 30;
        sink_stall_pct = 20;
        foreach (chars[i])
            send_char(chars[i]);
        settle(5000);
    endtask

    task automatic test_length_extremes();
        load_config('0, '0, '0, '0, '0);
        send_char(8'h51);
        send_char(ASCII_SPACE);
        send_char(8'h23);
        settle(5000);
        load_config('1, '1, '1, '1, '1);
        send_char(8'h59);
        send_char(ASCII_SPACE);
        send_char(8'hFF);
        settle(5000);
    endtask

    task automatic test_random_text();
        int                r;
        logic [CHAR_W-1:0] c;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                1:       load_config('0, '0, '0, '0, '0);
                2:       load_config('1, '1, '1, '1, '1);
                3:       load_config(4'd1, 4'd3, 4'd1, 4'd3, 4'd7);
                default: load_config(UNIT_W'($urandom), UNIT_W'($urandom),
                                     UNIT_W'($urandom), UNIT_W'($urandom),
                                     UNIT_W'($urandom));
            endcase
            src_stall_pct  = (p == 0) ? 0 : (p == 5) ? 50 : 20;
            sink_stall_pct = (p == 0) ? 0 : (p == 5) ? 40 : 15;
            for (int n = 0; n < 60; n++)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    c = ASCII_A + CHAR_W'($urandom_range(25));
                else if (r < 75)
                    c = ASCII_SPACE;
                else
                    c = CHAR_W'($urandom_range(255));
                send_char(c);
            end
            settle(5000);
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        char_if.valid     <= 1'b0;
        char_if.char_code <= '0;
        src_stall_pct     = 0;
        sink_stall_pct    = 0;
        bad_count         = 0;
        shown_count       = 0;
        dot_len           = DOT_RESET;
        dash_len          = DASH_RESET;
        sym_gap_len       = SYM_GAP_RESET;
        char_gap_len      = CHAR_GAP_RESET;
        space_len         = SPACE_RESET;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_keying();
        test_length_extremes();
        test_random_text();

        settle(5000);
        repeat (10) @(negedge clk);
        if (bad_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/mck_pkg.sv
design/mck_char_if.sv
design/mck_seg_if.sv
design/mck_ctrl.sv
design/mck_datapath.sv
design/morse_character_keyer.sv
design/mck_checker.sv
verif/morse_character_keyer_tb.sv
